// ===== rtl/assert_macros.svh =====
// Assertion macros for the checker file bpq_checker.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge, off while reset is asserted.
`define BPQ_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("bpq assertion failed");

// Same check, also active during reset.
`define BPQ_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("bpq assertion failed");

`endif

// ===== rtl/bpq_pkg.sv =====
// Shared widths, types and register codes for the box/point query block.
// No dependencies.
`default_nettype none

package bpq_pkg;

    localparam int COORD_FRAC_BITS = 16;
    localparam int COORD_W         = COORD_FRAC_BITS + 1;
    localparam int NUM_AXES        = 3;
    localparam int SQ_W            = 2 * COORD_W;
    localparam int SUM_W           = SQ_W + 2;
    // root pipeline: two result bits per stage
    localparam int ISQ_STAGES      = (COORD_W + 2) / 2;
    localparam int RT_W            = 2 * ISQ_STAGES;
    localparam int FRONT_STAGES    = 3;
    localparam int LATENCY         = FRONT_STAGES + ISQ_STAGES;

    localparam int DATA_W          = 32;
    localparam int REG_IDX_W       = 3;
    localparam int ADDR_W          = REG_IDX_W + 2;

    typedef logic [COORD_W-1:0] coord_t;

    typedef struct packed {
        logic closed;
        logic strict;
        logic overlap;
    } flags_t;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_BOX_LO_X = 3'd0,
        REG_BOX_LO_Y = 3'd1,
        REG_BOX_LO_Z = 3'd2,
        REG_BOX_HI_X = 3'd3,
        REG_BOX_HI_Y = 3'd4,
        REG_BOX_HI_Z = 3'd5
    } reg_idx_t;

endpackage

`default_nettype wire

// ===== rtl/box_point_query_3d.sv =====
// Items pass the front registers of stages 1, 2 and 3, then the ISQ_STAGES root stages.
// Throughput: one item per cycle while the output is not stalled; every stage register
// loads when it is empty or its item moves on, so bubbles collapse and a stall
// loses nothing. The root pipeline (two result bits per stage) sets the depth.
// Reset: rst_n asynchronous active low; clears valid bits and the box to zero.
// Depends on bpq_pkg and bpq_isqrt.
`default_nettype none

module box_point_query_3d
    import bpq_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    // configuration port
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0]      prdata,
    output logic                   pready,
    // query items
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire coord_t            point_x,
    input  wire coord_t            point_y,
    input  wire coord_t            point_z,
    input  wire coord_t            other_lo_x,
    input  wire coord_t            other_lo_y,
    input  wire coord_t            other_lo_z,
    input  wire coord_t            other_hi_x,
    input  wire coord_t            other_hi_y,
    input  wire coord_t            other_hi_z,
    // result items
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic                   inside_closed,
    output logic                   inside_strict,
    output logic                   boxes_overlap,
    output coord_t                 distance
);

    // ------------------------------------------------------------------
    // Configuration registers: box bounds, index = paddr word offset.
    // Writes beyond the six registers are dropped; reads return zero.
    // ------------------------------------------------------------------
    coord_t   box_lo_reg [NUM_AXES];
    coord_t   box_hi_reg [NUM_AXES];
    reg_idx_t cfg_idx;
    logic     cfg_wr;

    assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < NUM_AXES; a++)
            begin
                box_lo_reg[a] <= '0;
                box_hi_reg[a] <= '0;
            end
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_BOX_LO_X: box_lo_reg[0] <= pwdata[COORD_W-1:0];
                REG_BOX_LO_Y: box_lo_reg[1] <= pwdata[COORD_W-1:0];
                REG_BOX_LO_Z: box_lo_reg[2] <= pwdata[COORD_W-1:0];
                REG_BOX_HI_X: box_hi_reg[0] <= pwdata[COORD_W-1:0];
                REG_BOX_HI_Y: box_hi_reg[1] <= pwdata[COORD_W-1:0];
                REG_BOX_HI_Z: box_hi_reg[2] <= pwdata[COORD_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_BOX_LO_X: prdata = DATA_W'(box_lo_reg[0]);
            REG_BOX_LO_Y: prdata = DATA_W'(box_lo_reg[1]);
            REG_BOX_LO_Z: prdata = DATA_W'(box_lo_reg[2]);
            REG_BOX_HI_X: prdata = DATA_W'(box_hi_reg[0]);
            REG_BOX_HI_Y: prdata = DATA_W'(box_hi_reg[1]);
            REG_BOX_HI_Z: prdata = DATA_W'(box_hi_reg[2]);
            default:      prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Stage 1: per-axis compares and outside gaps.
    // Gap is lo - p below the box, p - hi above it, zero between. An
    // inverted box takes the same tests, so nothing is ever inside it.
    // ------------------------------------------------------------------
    coord_t pt   [NUM_AXES];
    coord_t olo  [NUM_AXES];
    coord_t ohi  [NUM_AXES];
    coord_t gap1_next [NUM_AXES];
    coord_t gap1_reg  [NUM_AXES];
    flags_t flg1_next;
    flags_t flg1_reg;
    logic   v1_reg;

    assign pt[0]  = point_x;
    assign pt[1]  = point_y;
    assign pt[2]  = point_z;
    assign olo[0] = other_lo_x;
    assign olo[1] = other_lo_y;
    assign olo[2] = other_lo_z;
    assign ohi[0] = other_hi_x;
    assign ohi[1] = other_hi_y;
    assign ohi[2] = other_hi_z;

    always_comb
    begin
        flg1_next = '{closed: 1'b1, strict: 1'b1, overlap: 1'b1};
        for (int a = 0; a < NUM_AXES; a++)
        begin
            if (pt[a] < box_lo_reg[a])
                gap1_next[a] = box_lo_reg[a] - pt[a];
            else if (pt[a] > box_hi_reg[a])
                gap1_next[a] = pt[a] - box_hi_reg[a];
            else
                gap1_next[a] = '0;
            if (!(box_lo_reg[a] <= pt[a] && pt[a] <= box_hi_reg[a]))
                flg1_next.closed = 1'b0;
            if (!(box_lo_reg[a] < pt[a] && pt[a] < box_hi_reg[a]))
                flg1_next.strict = 1'b0;
            if (box_hi_reg[a] < olo[a] || ohi[a] < box_lo_reg[a])
                flg1_next.overlap = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: squared gaps, one multiplier per axis.
    // Stage 3: sum of squares; fits SUM_W bits, so no saturation needed.
    // ------------------------------------------------------------------
    logic [SQ_W-1:0]  sq2_next [NUM_AXES];
    logic [SQ_W-1:0]  sq2_reg  [NUM_AXES];
    flags_t           flg2_reg;
    logic             v2_reg;
    logic [SUM_W-1:0] sum3_next;
    logic [SUM_W-1:0] sum3_reg;
    flags_t           flg3_reg;
    logic             v3_reg;

    always_comb
    begin
        for (int a = 0; a < NUM_AXES; a++)
        begin
            sq2_next[a] = SQ_W'(gap1_reg[a]) * SQ_W'(gap1_reg[a]);
        end
    end

    assign sum3_next = SUM_W'(sq2_reg[0]) + SUM_W'(sq2_reg[1]) + SUM_W'(sq2_reg[2]);

    // ------------------------------------------------------------------
    // Front pipeline flow control: a stage loads when empty or draining.
    // ------------------------------------------------------------------
    logic ld1;
    logic ld2;
    logic ld3;
    logic sq_in_ready;

    assign ld3      = !v3_reg || sq_in_ready;
    assign ld2      = !v2_reg || ld3;
    assign ld1      = !v1_reg || ld2;
    assign in_ready = ld1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (ld1) v1_reg <= in_valid;
            if (ld2) v2_reg <= v1_reg;
            if (ld3) v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld1)
        begin
            gap1_reg <= gap1_next;
            flg1_reg <= flg1_next;
        end
        if (ld2)
        begin
            sq2_reg  <= sq2_next;
            flg2_reg <= flg1_reg;
        end
        if (ld3)
        begin
            sum3_reg <= sum3_next;
            flg3_reg <= flg2_reg;
        end
    end

    // ------------------------------------------------------------------
    // Root pipeline, flags ride along as the tag.
    // ------------------------------------------------------------------
    logic [RT_W-1:0] sq_root;
    flags_t          sq_flags;
    logic            root_sat;

    bpq_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v3_reg),
        .in_ready  (sq_in_ready),
        .in_value  (sum3_reg),
        .in_tag    (flg3_reg),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_root  (sq_root),
        .out_tag   (sq_flags)
    );

    // root above the field maximum saturates
    assign root_sat      = |sq_root[RT_W-1:COORD_W];
    assign distance      = root_sat ? {COORD_W{1'b1}} : sq_root[COORD_W-1:0];
    assign inside_closed = sq_flags.closed;
    assign inside_strict = sq_flags.strict;
    assign boxes_overlap = sq_flags.overlap;

endmodule

`default_nettype wire

// ===== rtl/bpq_isqrt.sv =====
// Pipelined floor square root, two result bits per stage, with a side tag.
// Depends on bpq_pkg.
`default_nettype none

module bpq_isqrt
    import bpq_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [SUM_W-1:0] in_value,
    input  wire flags_t           in_tag,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [RT_W-1:0]       out_root,
    output flags_t                out_tag
);

    localparam int NS    = ISQ_STAGES;
    localparam int PAD_W = 2 * RT_W;
    localparam int REM_W = RT_W + 2;

    typedef struct packed {
        logic [PAD_W-1:0] val;
        logic [REM_W-1:0] rem;
        logic [RT_W-1:0]  root;
        flags_t           tag;
    } isq_t;

    // one restoring iteration: consume the top two bits of val
    function automatic isq_t isq_step(input isq_t s);
        isq_t             r;
        logic [REM_W-1:0] rs;
        logic [REM_W-1:0] trial;
        r     = s;
        rs    = {s.rem[REM_W-3:0], s.val[PAD_W-1 -: 2]};
        trial = {s.root, 2'b01};
        if (rs >= trial)
        begin
            r.rem  = rs - trial;
            r.root = {s.root[RT_W-2:0], 1'b1};
        end
        else
        begin
            r.rem  = rs;
            r.root = {s.root[RT_W-2:0], 1'b0};
        end
        r.val = s.val << 2;
        return r;
    endfunction

    isq_t          st_reg  [NS];
    isq_t          st_next [NS];
    logic [NS-1:0] vld_reg;
    logic [NS-1:0] vld_next;
    logic [NS-1:0] ld;
    isq_t          src;

    always_comb
    begin
        ld[NS-1] = !vld_reg[NS-1] || out_ready;
        for (int i = NS - 2; i >= 0; i--)
        begin
            ld[i] = !vld_reg[i] || ld[i+1];
        end
    end

    always_comb
    begin
        src = '0;
        for (int i = 0; i < NS; i++)
        begin
            if (i == 0)
            begin
                src.val  = PAD_W'(in_value);
                src.rem  = '0;
                src.root = '0;
                src.tag  = in_tag;
                vld_next[i] = ld[i] ? in_valid : vld_reg[i];
            end
            else
            begin
                src = st_reg[i-1];
                vld_next[i] = ld[i] ? vld_reg[i-1] : vld_reg[i];
            end
            st_next[i] = isq_step(isq_step(src));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NS; i++)
        begin
            if (ld[i])
            begin
                st_reg[i] <= st_next[i];
            end
        end
    end

    assign in_ready  = ld[0];
    assign out_valid = vld_reg[NS-1];
    assign out_root  = st_reg[NS-1].root;
    assign out_tag   = st_reg[NS-1].tag;

endmodule

`default_nettype wire

// ===== rtl/bpq_checker.sv =====
// Port-level checks on box_point_query_3d, attached by bind.
// Depends on bpq_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module bpq_checker
    import bpq_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              pready,
    input wire logic              out_valid,
    input wire logic              out_ready,
    input wire logic              inside_closed,
    input wire logic              inside_strict,
    input wire logic              boxes_overlap,
    input wire logic [COORD_W-1:0] distance
);

    // whole result payload, for the hold check
    logic [COORD_W+2:0] out_bundle;

    assign out_bundle = {inside_closed, inside_strict, boxes_overlap, distance};

    // a stalled result keeps valid and payload
    `BPQ_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid)
    `BPQ_ASSERT(a_out_stable, clk, rst_n, out_valid && !out_ready |=> $stable(out_bundle))

    // strictly inside implies inside with bounds
    `BPQ_ASSERT(a_strict_in_closed, clk, rst_n, out_valid && inside_strict |-> inside_closed)

    // a point in the box has zero distance, one outside has a nonzero one
    `BPQ_ASSERT(a_dist_zero, clk, rst_n, out_valid |-> (inside_closed == (distance == '0)))

    `BPQ_ASSERT_ALWAYS(a_pready, clk, pready)

endmodule

bind box_point_query_3d bpq_checker u_bpq_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .pready        (pready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .inside_closed (inside_closed),
    .inside_strict (inside_strict),
    .boxes_overlap (boxes_overlap),
    .distance      (distance)
);

`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking bench for box_point_query_3d: streams point/box query items under
// several box settings and pacing modes, predicts every result from its own box copy.
// Depends on bpq_pkg and the box_point_query_3d RTL.

module testbench
    import bpq_pkg::*;
();

    localparam int HALF_PERIOD     = 6;
    localparam int RESET_CYCLES    = 5;
    localparam int QUIET_LIMIT     = 1500;
    localparam int ITEMS_PER_PHASE = 175;
    localparam int RANDOM_PHASES   = 8;

    localparam coord_t COORD_TOP = '1;
    localparam coord_t UNIT      = coord_t'(1) << COORD_FRAC_BITS;

    // register slots past the box: writes there must leave the box alone
    localparam logic [REG_IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_SPARE_B = 3'd7;

    typedef coord_t [NUM_AXES-1:0] vec_t;     // element 0 is x

    typedef struct packed {
        vec_t pt;
        vec_t olo;
        vec_t ohi;
    } query_t;

    typedef struct packed {
        logic   closed;
        logic   strict;
        logic   overlap;
        coord_t clearance;
    } answer_t;

    // ------------------------------------------------------------------
    // DUT signals, all known from time zero
    // ------------------------------------------------------------------
    logic              clk        = 1'b0;
    logic              rst_n      = 1'b0;
    logic              psel       = 1'b0;
    logic              penable    = 1'b0;
    logic              pwrite     = 1'b0;
    logic [ADDR_W-1:0] paddr      = '0;
    logic [DATA_W-1:0] pwdata     = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              in_valid   = 1'b0;
    logic              in_ready;
    coord_t            point_x    = '0;
    coord_t            point_y    = '0;
    coord_t            point_z    = '0;
    coord_t            other_lo_x = '0;
    coord_t            other_lo_y = '0;
    coord_t            other_lo_z = '0;
    coord_t            other_hi_x = '0;
    coord_t            other_hi_y = '0;
    coord_t            other_hi_z = '0;
    logic              out_valid;
    logic              out_ready  = 1'b0;
    logic              inside_closed;
    logic              inside_strict;
    logic              boxes_overlap;
    coord_t            distance;

    // ------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------
    vec_t        box_lo = '0;            // our copy of the configured box
    vec_t        box_hi = '0;
    query_t      pending_queries[$];     // items waiting for the driver
    answer_t     expected_answers[$];    // predictions of accepted items, oldest first
    query_t      cur_query;              // item on the input port
    answer_t     seen_answer;            // result caught at the last edge
    logic        got_answer = 1'b0;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int          errors          = 0;
    int          results_checked = 0;
    int          box_settings    = 0;
    int          quiet_cycles    = 0;

    box_point_query_3d uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .point_x      (point_x),
        .point_y      (point_y),
        .point_z      (point_z),
        .other_lo_x   (other_lo_x),
        .other_lo_y   (other_lo_y),
        .other_lo_z   (other_lo_z),
        .other_hi_x   (other_hi_x),
        .other_hi_y   (other_hi_y),
        .other_hi_z   (other_hi_z),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .inside_closed(inside_closed),
        .inside_strict(inside_strict),
        .boxes_overlap(boxes_overlap),
        .distance     (distance)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // ------------------------------------------------------------------
    // Prediction: containment, overlap and clearance to the held box
    // ------------------------------------------------------------------
    function automatic answer_t predict_answer(query_t q);
        answer_t          a;
        coord_t           gap;
        longint unsigned  sq_sum;
        longint unsigned  root;
        longint unsigned  trial;
        a.closed  = 1'b1;
        a.strict  = 1'b1;
        a.overlap = 1'b1;
        sq_sum    = 0;
        for (int i = 0; i < NUM_AXES; i++)
        begin
            if (q.pt[i] < box_lo[i] || q.pt[i] > box_hi[i])
                a.closed = 1'b0;
            if (q.pt[i] <= box_lo[i] || q.pt[i] >= box_hi[i])
                a.strict = 1'b0;
            // touching faces still count as overlap
            if (box_hi[i] < q.olo[i] || q.ohi[i] < box_lo[i])
                a.overlap = 1'b0;
            // an inverted box has no middle: one of the first two arms always fires
            if (q.pt[i] < box_lo[i])
                gap = box_lo[i] - q.pt[i];
            else if (q.pt[i] > box_hi[i])
                gap = q.pt[i] - box_hi[i];
            else
                gap = '0;
            sq_sum += 64'(gap) * 64'(gap);
        end
        // floor root, one bit at a time from the top; sum < 2^36 so 18 bits do
        root = 0;
        for (int b = 17; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (trial * trial <= sq_sum)
                root = trial;
        end
        // far corners clip to the largest code the port holds
        a.clearance = (root > 64'(COORD_TOP)) ? COORD_TOP : coord_t'(root);
        return a;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic vec_t xyz(coord_t x, coord_t y, coord_t z);
        return {z, y, x};
    endfunction

    function automatic coord_t span_pick(coord_t a, coord_t b);
        return (a <= b) ? coord_t'($urandom_range(32'(b), 32'(a)))
                        : coord_t'($urandom_range(32'(a), 32'(b)));
    endfunction

    // one coordinate, weighted toward the faces of the box
    function automatic coord_t pick_coord(coord_t lo, coord_t hi);
        coord_t c;
        case ($urandom_range(5))
            0:       c = coord_t'($urandom);                         // any 17-bit code
            1:       c = coord_t'($urandom_range(32'(UNIT)));        // unit range
            2:       c = lo + coord_t'($urandom_range(2)) - coord_t'(1);
            3:       c = hi + coord_t'($urandom_range(2)) - coord_t'(1);
            4:       c = span_pick(lo, hi);
            default: c = $urandom_range(1) ? COORD_TOP : '0;
        endcase
        return c;
    endfunction

    function automatic query_t rand_query();
        query_t q;
        logic   hug;
        coord_t t;
        hug = ($urandom_range(2) == 0);   // aim the point inside the box on all axes
        for (int i = 0; i < NUM_AXES; i++)
        begin
            q.pt[i]  = hug ? span_pick(box_lo[i], box_hi[i]) : pick_coord(box_lo[i], box_hi[i]);
            q.olo[i] = pick_coord(box_lo[i], box_hi[i]);
            q.ohi[i] = pick_coord(box_lo[i], box_hi[i]);
            // mostly proper second boxes, some left inverted
            if (q.olo[i] > q.ohi[i] && $urandom_range(4) != 0)
            begin
                t        = q.olo[i];
                q.olo[i] = q.ohi[i];
                q.ohi[i] = t;
            end
        end
        return q;
    endfunction

    task automatic add_query(vec_t pt, vec_t olo, vec_t ohi);
        query_t q;
        q.pt  = pt;
        q.olo = olo;
        q.ohi = ohi;
        pending_queries = {pending_queries, q};
    endtask

    // ------------------------------------------------------------------
    // Register access; only called while the datapath is empty
    // ------------------------------------------------------------------
    task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input coord_t value);
        logic [DATA_W-1:0] word;
        // junk above bit 16 must be dropped by the register
        word = ($urandom & ~DATA_W'(COORD_TOP)) | DATA_W'(value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(idx) << 2;
        pwdata  <= word;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_BOX_LO_X: box_lo[0] = value;
            REG_BOX_LO_Y: box_lo[1] = value;
            REG_BOX_LO_Z: box_lo[2] = value;
            REG_BOX_HI_X: box_hi[0] = value;
            REG_BOX_HI_Y: box_hi[1] = value;
            REG_BOX_HI_Z: box_hi[2] = value;
            default: ;   // spare slot: no effect
        endcase
    endtask

    task automatic reg_check(input reg_idx_t idx, input coord_t want);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_W'(idx) << 2;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        // prdata seen here is the value held through the access cycle
        if (prdata[COORD_W-1:0] !== want)
        begin
            $error("register %s: expected %0h, got %0h", idx.name(), want,
                   prdata[COORD_W-1:0]);
            errors++;
        end
    endtask

    task automatic check_box();
        reg_check(REG_BOX_LO_X, box_lo[0]);
        reg_check(REG_BOX_LO_Y, box_lo[1]);
        reg_check(REG_BOX_LO_Z, box_lo[2]);
        reg_check(REG_BOX_HI_X, box_hi[0]);
        reg_check(REG_BOX_HI_Y, box_hi[1]);
        reg_check(REG_BOX_HI_Z, box_hi[2]);
    endtask

    task automatic configure_box(vec_t lo, vec_t hi);
        reg_write(REG_BOX_LO_X, lo[0]);
        reg_write(REG_BOX_LO_Y, lo[1]);
        reg_write(REG_BOX_LO_Z, lo[2]);
        reg_write(REG_BOX_HI_X, hi[0]);
        reg_write(REG_BOX_HI_Y, hi[1]);
        reg_write(REG_BOX_HI_Z, hi[2]);
        reg_write(REG_SPARE_A, coord_t'($urandom));
        reg_write(REG_SPARE_B, coord_t'($urandom));
        check_box();
        box_settings++;
    endtask

    // Random box of a given flavor: plain, full span, flat, inverted, above 1.0
    task automatic rand_box(input int style, output vec_t lo, output vec_t hi);
        coord_t a;
        coord_t b;
        int     ax;
        for (int i = 0; i < NUM_AXES; i++)
        begin
            a = coord_t'($urandom_range(32'(UNIT)));
            b = coord_t'($urandom_range(32'(UNIT)));
            lo[i] = (a < b) ? a : b;
            hi[i] = (a < b) ? b : a;
            case (style)
                1:
                begin
                    lo[i] = '0;
                    hi[i] = COORD_TOP;
                end
                2:       hi[i] = lo[i];
                4:
                begin
                    lo[i] = coord_t'($urandom_range(32'(COORD_TOP), 32'(UNIT)));
                    hi[i] = COORD_TOP;
                end
                default: ;
            endcase
        end
        if (style == 3)
        begin
            ax     = $urandom_range(NUM_AXES - 1);
            a      = lo[ax];
            lo[ax] = hi[ax] + coord_t'(1);
            hi[ax] = a;
        end
    endtask

    // Sender holds off until the pipe has handed back every result
    task automatic drain();
        do
            @(negedge clk);
        while (pending_queries.size() != 0 || in_valid ||
               expected_answers.size() != 0 || got_answer);
    endtask

    // ------------------------------------------------------------------
    // Driver: presents queued items, records a prediction per accept
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : query_driver
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && in_ready)
                expected_answers = {expected_answers, predict_answer(cur_query)};
            if (!in_valid || in_ready)
            begin
                if (pending_queries.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    cur_query  = pending_queries.pop_front();
                    point_x    <= cur_query.pt[0];
                    point_y    <= cur_query.pt[1];
                    point_z    <= cur_query.pt[2];
                    other_lo_x <= cur_query.olo[0];
                    other_lo_y <= cur_query.olo[1];
                    other_lo_z <= cur_query.olo[2];
                    other_hi_x <= cur_query.ohi[0];
                    other_hi_y <= cur_query.ohi[1];
                    other_hi_z <= cur_query.ohi[2];
                    in_valid   <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: a result caught at one edge is checked at the next, so the
    // driver's push at that edge can never race the compare.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : result_monitor
        answer_t want;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (got_answer)
            begin
                if (expected_answers.size() == 0)
                begin
                    $error("result arrived with no query outstanding");
                    errors++;
                end
                else
                begin
                    want = expected_answers.pop_front();
                    results_checked++;
                    if (seen_answer.closed !== want.closed)
                    begin
                        $error("inside_closed: expected %0d, got %0d",
                               want.closed, seen_answer.closed);
                        errors++;
                    end
                    if (seen_answer.strict !== want.strict)
                    begin
                        $error("inside_strict: expected %0d, got %0d",
                               want.strict, seen_answer.strict);
                        errors++;
                    end
                    if (seen_answer.overlap !== want.overlap)
                    begin
                        $error("boxes_overlap: expected %0d, got %0d",
                               want.overlap, seen_answer.overlap);
                        errors++;
                    end
                    if (seen_answer.clearance !== want.clearance)
                    begin
                        $error("distance: expected %0d, got %0d",
                               want.clearance, seen_answer.clearance);
                        errors++;
                    end
                end
            end
            got_answer            = out_valid && out_ready;
            seen_answer.closed    = inside_closed;
            seen_answer.strict    = inside_strict;
            seen_answer.overlap   = boxes_overlap;
            seen_answer.clearance = distance;
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: too long with no item moving on either side, nor a register access
    always @(posedge clk)
    begin : hang_watch
        if (!rst_n || psel || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("timeout: nothing moved for %0d cycles", QUIET_LIMIT);
            $display("testbench failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence: reset, directed corners, then random phases
    // ------------------------------------------------------------------
    initial
    begin : scenario
        vec_t top_v;
        vec_t b_lo;
        vec_t b_hi;
        vec_t mid;
        vec_t p;
        vec_t o;
        vec_t r_lo;
        vec_t r_hi;

        top_v = {NUM_AXES{COORD_TOP}};
        b_lo  = xyz(17'h04000, 17'h02000, 17'h06000);
        b_hi  = xyz(17'h0C000, 17'h0E000, 17'h09000);
        mid   = xyz(17'h08000, 17'h08000, 17'h07800);

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        check_box();               // box reads back as zero after reset

        // zero box: the origin sits on it, the far corner clips the distance
        @(negedge clk);
        add_query('0, '0, '0);
        add_query(top_v, top_v, top_v);
        add_query(xyz(UNIT, '0, '0), '0, top_v);
        drain();

        // ordinary box: faces, one step outside each face, touching boxes
        configure_box(b_lo, b_hi);
        @(negedge clk);
        add_query(b_lo, b_lo, b_hi);
        add_query(b_hi, b_lo, b_hi);
        add_query(mid, b_lo, b_hi);
        for (int i = 0; i < NUM_AXES; i++)
        begin
            p    = mid;
            p[i] = b_lo[i] - coord_t'(1);
            add_query(p, b_lo, b_hi);
            p[i] = b_hi[i] + coord_t'(1);
            add_query(p, b_lo, b_hi);
        end
        add_query('0, '0, '0);
        o    = b_lo;
        o[0] = b_hi[0];                        // starts on the upper x face
        add_query(mid, o, top_v);
        o[0] = b_hi[0] + coord_t'(1);          // one past it
        add_query(mid, o, top_v);
        o    = top_v;
        o[0] = b_lo[0];                        // ends on the lower x face
        add_query(mid, '0, o);
        o[0] = b_lo[0] - coord_t'(1);
        add_query(mid, '0, o);
        add_query(mid, b_hi, b_lo);            // second box turned inside out
        p    = mid;
        p[0] = COORD_TOP;                      // coordinate above 1.0
        add_query(p, b_lo, b_hi);
        drain();

        // inverted x: nothing is inside, gaps come from whichever face is crossed
        r_lo    = b_lo;
        r_hi    = b_hi;
        r_lo[0] = 17'h0C000;
        r_hi[0] = 17'h04000;
        configure_box(r_lo, r_hi);
        @(negedge clk);
        add_query(mid, r_lo, r_hi);
        p    = mid;
        p[0] = 17'h0C000;
        add_query(p, r_lo, r_hi);
        p[0] = 17'h04000;
        add_query(p, r_lo, r_hi);
        drain();

        // random phases: every box flavor, every pacing mode
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            rand_box(ph % 5, r_lo, r_hi);
            configure_box(r_lo, r_hi);
            @(negedge clk);
            case (ph % 4)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 82;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 82;
                end
                default:
                begin
                    send_idle_pct  = 37;
                    recv_stall_pct = 37;
                end
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                pending_queries = {pending_queries, rand_query()};
            drain();
        end

        // let any stray result show itself before closing
        repeat (LATENCY + 4) @(negedge clk);
        if (expected_answers.size() != 0 || got_answer)
        begin
            $error("results outstanding at end of run: %0d", expected_answers.size());
            errors++;
        end

        $display("checked %0d query results over %0d box settings", results_checked,
                 box_settings);
        $display("pacing: free flow, sparse sender, stalling receiver, both throttled");
        if (errors == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
